// ===== hw/rtl/mmdf_pkg.sv =====
package mmdf_pkg;

	localparam int DEPTH_DEFAULT = 8;

	localparam logic [7:0]  KIND_OK      = 8'h62;  // ASCII 'b'
	localparam logic [7:0]  CLASS_OK     = 8'h31;  // ASCII '1'
	localparam logic [15:0] BROADCAST_ID = 16'hFFFF;
	localparam logic [31:0] WINDOW_RESET = 32'd60000;

	// Configuration register indexes
	localparam logic CFG_OWN_ID = 1'b0;
	localparam logic CFG_WINDOW = 1'b1;

	// Item kinds on the message channel
	localparam logic CMD_HEADER = 1'b0;
	localparam logic CMD_DEST   = 1'b1;

	typedef enum logic [1:0] {
		STAT_STORED     = 2'd0,
		STAT_WRONG_TYPE = 2'd1,
		STAT_NOT_ADDR   = 2'd2,
		STAT_DUPLICATE  = 2'd3
	} status_t;

	// One ring entry; also the layout of the header being collected
	typedef struct packed {
		logic [15:0] sender;
		logic [7:0]  seq;
		logic [31:0] rx_ms;
		logic [15:0] reply_id;
		logic [7:0]  reply_seq;
		logic [15:0] msgid;
		logic [3:0]  dcount;
	} entry_t;

endpackage

// ===== hw/rtl/mmdf_if.sv =====
interface mmdf_msg_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [15:0] sender_id;
	logic [7:0]  sender_seq;
	logic [15:0] reply_id;
	logic [7:0]  reply_seq;
	logic [7:0]  msg_id;
	logic [7:0]  msg_id2;
	logic [3:0]  dest_count;
	logic [7:0]  kind_char;
	logic [7:0]  class_char;
	logic [31:0] now_ms;
	logic [15:0] dest_id;

	modport source (output valid, cmd, sender_id, sender_seq, reply_id, reply_seq, msg_id,
		msg_id2, dest_count, kind_char, class_char, now_ms, dest_id, input ready);
	modport sink (input valid, cmd, sender_id, sender_seq, reply_id, reply_seq, msg_id,
		msg_id2, dest_count, kind_char, class_char, now_ms, dest_id, output ready);
endinterface

interface mmdf_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [5:0] slot;
	logic [6:0] stored_count;

	modport source (output valid, status, slot, stored_count, input ready);
	modport sink (input valid, status, slot, stored_count, output ready);
endinterface

interface mmdf_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/mesh_message_dedup_filter.sv =====
// Duplicate message suppression cache for a mesh node.
// Channels: msg (sink) takes a header beat (cmd 0) followed by dest_count
// destination beats (cmd 1). res (source) gives at most one decision beat
// per message: stored, wrong type, not addressed, or duplicate, with the
// ring slot written and the number of valid entries. cfg (sink) writes
// own_id (index 0) and the duplicate window in ms (index 1); always ready.
// One beat is handled at a time. A header rejected at once, or a message
// not addressed here, goes through the emit state to the res output
// register. An addressed message is checked against the stored entries one
// per cycle through the ring memory's single read port, and a duplicate
// ends the scan early.
// Reset clears the ring fill count, write pointer, unread flags and the
// collection state; the ring memory itself holds no reset value and is
// only read below the fill count.
// res is a registered output: a stalled receiver holds its beat while the
// next message beats are still taken; only a second result waits.
module mesh_message_dedup_filter
	import mmdf_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	mmdf_msg_if.sink   msg,
	mmdf_res_if.source res,
	mmdf_cfg_if.sink   cfg
);

	localparam int SlotW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW  = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} state_t;

	state_t state_q;

	// configuration
	logic [15:0] own_id_q;
	logic [31:0] window_q;

	// message being collected
	entry_t      pend_q;
	logic [3:0]  dests_left_q;
	logic        addressed_q;
	logic        collecting_q;

	// ring bookkeeping
	logic [SlotW-1:0] wr_slot_q;
	logic [CntW-1:0]  count_q;
	logic [DEPTH-1:0] unread_q;

	// scan
	logic [CntW-1:0] rd_idx_q;
	logic            rd_vld_s1;
	entry_t          rd_data_s1;

	// pending result and output register
	status_t     res_status_q;
	logic [5:0]  res_slot_q;
	logic        out_valid_q;
	logic [1:0]  out_status_q;
	logic [5:0]  out_slot_q;
	logic [6:0]  out_count_q;

	entry_t mem [DEPTH];

	logic       msg_fire;
	logic       cfg_fire;
	logic       rd_en;
	logic       hit;
	logic       scan_done;
	logic       store_en;
	logic       dest_hit;
	logic [3:0] dests_next;
	logic       emit_go;

	assign msg.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign msg_fire  = msg.valid && msg.ready;
	assign cfg_fire  = cfg.valid && cfg.ready;

	assign res.valid        = out_valid_q;
	assign res.status       = out_status_q;
	assign res.slot         = out_slot_q;
	assign res.stored_count = out_count_q;

	always_comb begin
		rd_en     = (state_q == ST_SCAN) && (rd_idx_q != count_q);
		// wrapping age compared to the window
		hit       = rd_vld_s1 && (rd_data_s1.sender == pend_q.sender)
			&& (rd_data_s1.seq == pend_q.seq)
			&& ((pend_q.rx_ms - rd_data_s1.rx_ms) < window_q);
		scan_done = (state_q == ST_SCAN) && (rd_idx_q == count_q) && !rd_vld_s1;
		store_en  = scan_done;
		dest_hit  = (msg.dest_id == BROADCAST_ID) || (msg.dest_id == own_id_q);
		dests_next = (dests_left_q != 4'd0) ? dests_left_q - 4'd1 : 4'd0;
		// output register free or being emptied this cycle
		emit_go   = (state_q == ST_EMIT) && (!out_valid_q || res.ready);
	end

	// ring memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (store_en) begin
			mem[wr_slot_q] <= pend_q;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_idx_q[SlotW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			own_id_q     <= '0;
			window_q     <= WINDOW_RESET;
			pend_q       <= '0;
			dests_left_q <= '0;
			addressed_q  <= 1'b0;
			collecting_q <= 1'b0;
			wr_slot_q    <= '0;
			count_q      <= '0;
			unread_q     <= '0;
			rd_idx_q     <= '0;
			rd_vld_s1    <= 1'b0;
			res_status_q <= STAT_STORED;
			res_slot_q   <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= '0;
			out_slot_q   <= '0;
			out_count_q  <= '0;
		end else begin
			if (cfg_fire) begin
				unique case (cfg.index)
					CFG_OWN_ID: own_id_q <= cfg.data[15:0];
					CFG_WINDOW: window_q <= cfg.data;
					default: ;
				endcase
			end

			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					rd_idx_q  <= '0;
					rd_vld_s1 <= 1'b0;
					if (msg_fire) begin
						if (msg.cmd == CMD_HEADER) begin
							addressed_q  <= 1'b0;
							if (msg.kind_char != KIND_OK || msg.class_char != CLASS_OK) begin
								collecting_q <= 1'b0;
								res_status_q <= STAT_WRONG_TYPE;
								res_slot_q   <= '0;
								state_q      <= ST_EMIT;
							end else begin
								pend_q.sender    <= msg.sender_id;
								pend_q.seq       <= msg.sender_seq;
								pend_q.rx_ms     <= msg.now_ms;
								pend_q.reply_id  <= msg.reply_id;
								pend_q.reply_seq <= msg.reply_seq;
								pend_q.msgid     <= {msg.msg_id, msg.msg_id2};
								pend_q.dcount    <= msg.dest_count;
								dests_left_q     <= msg.dest_count;
								if (msg.dest_count == 4'd0) begin
									// nothing can address it
									collecting_q <= 1'b0;
									res_status_q <= STAT_NOT_ADDR;
									res_slot_q   <= '0;
									state_q      <= ST_EMIT;
								end else begin
									collecting_q <= 1'b1;
								end
							end
						end else if (collecting_q) begin
							addressed_q  <= addressed_q || dest_hit;
							dests_left_q <= dests_next;
							if (dests_next == 4'd0) begin
								collecting_q <= 1'b0;
								if (addressed_q || dest_hit) begin
									state_q <= ST_SCAN;
								end else begin
									res_status_q <= STAT_NOT_ADDR;
									res_slot_q   <= '0;
									state_q      <= ST_EMIT;
								end
							end
						end
					end
				end

				ST_SCAN: begin
					if (rd_en) begin
						rd_idx_q <= rd_idx_q + CntW'(1);
					end
					rd_vld_s1 <= rd_en && !hit;
					if (hit) begin
						res_status_q <= STAT_DUPLICATE;
						res_slot_q   <= '0;
						state_q      <= ST_EMIT;
					end else if (scan_done) begin
						unread_q[wr_slot_q] <= 1'b1;
						wr_slot_q <= (wr_slot_q == SlotW'(DEPTH - 1)) ? '0 : wr_slot_q + SlotW'(1);
						if (count_q != CntW'(DEPTH)) begin
							count_q <= count_q + CntW'(1);
						end
						res_status_q <= STAT_STORED;
						res_slot_q   <= 6'(wr_slot_q);
						state_q      <= ST_EMIT;
					end
				end

				ST_EMIT: begin
					if (emit_go) begin
						out_status_q <= res_status_q;
						out_slot_q   <= res_slot_q;
						out_count_q  <= 7'(count_q);
						state_q      <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== hw/rtl/mmdf_checker.sv =====
module mmdf_checker
	import mmdf_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [1:0] res_status,
	input logic [5:0] res_slot,
	input logic [6:0] res_stored_count
);

	// stalled result beat holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_status)
			&& $stable(res_slot) && $stable(res_stored_count))
		else $error("result beat changed while stalled");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_stored_count <= 7'(DEPTH))
		else $error("stored count above depth");

	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status != STAT_STORED |-> res_slot == 6'd0)
		else $error("slot nonzero on a message not stored");

	// ring fills in order until it saturates
	a_fill_order: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status == STAT_STORED |->
			res_stored_count == 7'(DEPTH) || ({1'b0, res_slot} + 7'd1) == res_stored_count)
		else $error("stored slot out of fill order");

endmodule

bind mesh_message_dedup_filter mmdf_checker #(.DEPTH(DEPTH)) u_mmdf_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_status       (res.status),
	.res_slot         (res.slot),
	.res_stored_count (res.stored_count)
);
